### rtl/core/wavetable_oscillator_interp_top_defines.svh
// Assertion macros for the wavetable oscillator checker.
// Included by the checker file only; no other dependencies.
`ifndef WAVETABLE_OSCILLATOR_INTERP_TOP_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_INTERP_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define WTOSC_AST_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wtosc: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define WTOSC_AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wtosc: next-cycle check failed");

`endif

### rtl/core/wtosc_pkg.sv
// Shared types, constants and functions of the wavetable oscillator.
// No dependencies; imported by every module of the block.
package wtosc_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = 10;
    localparam int TABLE_DEPTH = 1 << IDX_W;
    localparam int PHASE_W     = IDX_W + FRAC_BITS;
    localparam int LEN_W       = IDX_W + 1;
    localparam int A440_W      = 26;
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 7;
    localparam int NOTE_W      = 7;
    localparam int RATIO_W     = 17;
    localparam int MUL_A_W     = 34;
    localparam int MUL_B_W     = 25;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    localparam logic [A440_W-1:0] A440_RESET = 26'd669571;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 11'd1024;
    localparam logic [LEN_W-1:0]  LEN_MIN    = 11'd2;
    localparam logic [LEN_W-1:0]  LEN_MAX    = 11'd1024;

    // floor(2^30 / 127), used to divide by 127
    localparam logic [23:0] RECIP_127   = 24'd8454660;
    localparam int          RECIP_SHIFT = 30;
    // 127 * 2^15: half of the gain divisor, for round-half-away
    localparam logic [39:0] ROUND_HALF  = 40'd4161536;
    // step shift for octave zero; the octave count is subtracted from it
    localparam logic [4:0]  SHIFT_BASE  = 5'd22;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_NOTE = 2'd1,
        OP_STOP = 2'd2,
        OP_TICK = 2'd3
    } t_op;

    typedef enum logic {
        REG_A440 = 1'b0,
        REG_LEN  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_op                        operation;
        logic [IDX_W-1:0]           table_index;
        logic signed [SAMPLE_W-1:0] table_value;
        logic [NOTE_W-1:0]          note;
        logic [GAIN_W-1:0]          velocity;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sounding;
    } t_out_word;

    typedef struct packed {
        logic [A440_W-1:0] a440_step;
        logic [LEN_W-1:0]  eff_len;
    } t_cfg;

    typedef struct packed {
        logic                we;
        logic [IDX_W-1:0]    addr;
        logic [SAMPLE_W-1:0] wdata;
    } t_tbl_req;

    typedef struct packed {
        logic [3:0] oct;
        logic [3:0] semi;
    } t_note_split;

    // 2^(k/12) in unsigned Q1.16, rounded to nearest
    function automatic logic [RATIO_W-1:0] semitone_ratio(input logic [3:0] s);
        logic [RATIO_W-1:0] r;
        case (s)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd69433;
            4'd2:    r = 17'd73562;
            4'd3:    r = 17'd77936;
            4'd4:    r = 17'd82570;
            4'd5:    r = 17'd87480;
            4'd6:    r = 17'd92682;
            4'd7:    r = 17'd98193;
            4'd8:    r = 17'd104032;
            4'd9:    r = 17'd110218;
            4'd10:   r = 17'd116772;
            4'd11:   r = 17'd123715;
            default: r = '0;
        endcase
        return r;
    endfunction

    // (note+3)/12 and (note+3)%12; 171/2048 is exact enough for n <= 130
    function automatic t_note_split note_split(input logic [NOTE_W-1:0] note);
        logic [7:0]  n;
        logic [15:0] m;
        logic [7:0]  o12;
        logic [7:0]  rem;
        t_note_split r;
        n      = {1'b0, note} + 8'd3;
        m      = {8'd0, n} * 16'd171;
        r.oct  = m[14:11];
        o12    = {1'b0, r.oct, 3'b000} + {2'b00, r.oct, 2'b00};
        rem    = n - o12;
        r.semi = rem[3:0];
        return r;
    endfunction

endpackage

### rtl/core/wtosc_cfg.sv
// APB-style register file: a440 step and table length.
// Depends on wtosc_pkg; exports the clamped table length.
module wtosc_cfg
    import wtosc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [A440_W-1:0] r_a440_step;
    logic [LEN_W-1:0]  r_table_length;
    logic              wr_en;
    t_reg_idx          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a440_step    <= A440_RESET;
            r_table_length <= LEN_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_A440: r_a440_step    <= pwdata[A440_W-1:0];
                REG_LEN:  r_table_length <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_A440: prdata = {{(32-A440_W){1'b0}}, r_a440_step};
            REG_LEN:  prdata = {{(32-LEN_W){1'b0}}, r_table_length};
            default:  prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.a440_step = r_a440_step;
        if (r_table_length < LEN_MIN) begin
            o_cfg.eff_len = LEN_MIN;
        end else if (r_table_length > LEN_MAX) begin
            o_cfg.eff_len = LEN_MAX;
        end else begin
            o_cfg.eff_len = r_table_length;
        end
    end

endmodule

### rtl/core/wtosc_mul.sv
// Shared signed multiplier with registered product.
// Depends on wtosc_pkg for operand widths.
module wtosc_mul
    import wtosc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

### rtl/core/wtosc_table.sv
// Wave table memory: one port, registered read each cycle, plus a write when enabled.
// Depends on wtosc_pkg for the request struct and depth.
module wtosc_table
    import wtosc_pkg::*;
(
    input  logic                i_clk,
    input  t_tbl_req            i_req,
    output logic [SAMPLE_W-1:0] o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [TABLE_DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/wavetable_oscillator_interp_top.sv
// Channel   | handshake              | payload
// input     | i_valid / o_ready      | i_data  (t_in_word)
// output    | o_valid / i_ready      | o_data  (t_out_word)
// config    | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// A load or stop word ends in S_IDLE; a note on passes S_NMUL and S_NFIN;
// a sounding tick does two reads of the single-port table, then three passes
// through the shared multiplier: slope times fraction, times gain, times 1/127.
// A tick result sits in an output register; the next word is accepted while
// it waits. A tick finishing while that register is still full holds.
// Reset is synchronous, active low; table contents are not cleared.
// Depends on wtosc_pkg, wtosc_cfg, wtosc_mul, wtosc_table.
module wavetable_oscillator_interp_top
    import wtosc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_word    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_word   o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_NMUL = 12'b0000_0000_0010,
        S_NFIN = 12'b0000_0000_0100,
        S_RD0  = 12'b0000_0000_1000,
        S_RD1  = 12'b0000_0001_0000,
        S_MUL1 = 12'b0000_0010_0000,
        S_SUM  = 12'b0000_0100_0000,
        S_GAIN = 12'b0000_1000_0000,
        S_RND  = 12'b0001_0000_0000,
        S_DIV  = 12'b0010_0000_0000,
        S_FIX  = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [PHASE_W-1:0] r_step, n_step;
    logic [GAIN_W-1:0]  r_gain, n_gain;
    logic               r_active, n_active;
    logic [3:0]         r_oct, n_oct;
    logic [3:0]         r_semi, n_semi;
    logic [PHASE_W-1:0] r_st, n_st;
    logic [PHASE_W:0]   r_psum, n_psum;
    logic [15:0]        r_t0, n_t0;
    logic [32:0]        r_v, n_v;
    logic [22:0]        r_x, n_x;
    logic               r_neg, n_neg;
    logic [16:0]        r_q, n_q;
    logic               r_sound, n_sound;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    t_cfg                      cfg;
    t_tbl_req                  tbl_req;
    logic [SAMPLE_W-1:0]       t_rd;
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] m_p;

    logic               accept;
    logic               slot_free;
    logic [PHASE_W:0]   lim;
    logic [PHASE_W:0]   lim_m1;
    logic [PHASE_W-1:0] phase_eff;
    logic [PHASE_W-1:0] st_clamp;
    logic [IDX_W-1:0]   i0;
    logic [IDX_W:0]     i1_full;
    logic [IDX_W-1:0]   i1;
    logic [16:0]        dt;
    t_note_split        nsplit;
    logic [4:0]         sh;
    logic [43:0]        rsum;
    logic [43:0]        rshift;
    logic [39:0]        p_raw;
    logic [39:0]        p_mag;
    logic [39:0]        p_rnd;
    logic [16:0]        q0;
    logic [23:0]        q0x127;
    logic [23:0]        rem;
    logic [16:0]        neg_q;
    logic [15:0]        sat_val;

    wtosc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wtosc_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (m_p)
    );

    wtosc_table u_table (
        .i_clk   (i_clk),
        .i_req   (tbl_req),
        .o_rdata (t_rd)
    );

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid & o_ready;
    assign slot_free = !r_out_valid || i_ready;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    // phase limit L * 2^F and the wrapped / clamped working values
    assign lim       = {cfg.eff_len, {FRAC_BITS{1'b0}}};
    assign lim_m1    = lim - 1'b1;
    assign phase_eff = ({1'b0, r_phase} >= lim) ? '0 : r_phase;
    assign st_clamp  = ({1'b0, r_step} > lim_m1) ? lim_m1[PHASE_W-1:0] : r_step;

    assign i0      = r_phase[PHASE_W-1:FRAC_BITS];
    assign i1_full = {1'b0, i0} + 1'b1;
    assign i1      = (i1_full >= cfg.eff_len) ? '0 : i1_full[IDX_W-1:0];

    assign dt     = {t_rd[15], t_rd} - {r_t0[15], r_t0};
    assign nsplit = note_split(i_data.note);

    always_comb begin
        tbl_req.we    = accept && (i_data.operation == OP_LOAD);
        tbl_req.wdata = i_data.table_value;
        case (r_state)
            S_RD0:   tbl_req.addr = i0;
            S_RD1:   tbl_req.addr = i1;
            default: tbl_req.addr = i_data.table_index;
        endcase
    end

    always_comb begin
        mul_en = 1'b1;
        case (r_state)
            S_NMUL: begin
                mul_a = $signed({{(MUL_A_W-A440_W){1'b0}}, cfg.a440_step});
                mul_b = $signed({{(MUL_B_W-RATIO_W){1'b0}}, semitone_ratio(r_semi)});
            end
            S_MUL1: begin
                mul_a = $signed({{(MUL_A_W-17){dt[16]}}, dt});
                mul_b = $signed({{(MUL_B_W-FRAC_BITS){1'b0}}, r_phase[FRAC_BITS-1:0]});
            end
            S_GAIN: begin
                mul_a = $signed({r_v[32], r_v});
                mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, r_gain});
            end
            S_DIV: begin
                mul_a = $signed({{(MUL_A_W-23){1'b0}}, r_x});
                mul_b = $signed({1'b0, RECIP_127});
            end
            default: begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    // note on: round-half-up shift of a440 * ratio by 22 - octave
    assign sh     = SHIFT_BASE - {1'b0, r_oct};
    assign rsum   = {1'b0, m_p[42:0]} + (44'd1 << (sh - 5'd1));
    assign rshift = rsum >> sh;

    // gain product magnitude, rounded, then scaled down by 2^F
    assign p_raw = m_p[39:0];
    assign p_mag = p_raw[39] ? (40'd0 - p_raw) : p_raw;
    assign p_rnd = p_mag + ROUND_HALF;

    // quotient estimate is exact or one low
    assign q0     = m_p[RECIP_SHIFT+16:RECIP_SHIFT];
    assign q0x127 = {q0, 7'b0} - {7'b0, q0};
    assign rem    = {1'b0, r_x} - q0x127;

    assign neg_q = 17'd0 - r_q;
    always_comb begin
        if (r_neg) begin
            sat_val = (r_q > 17'd32768) ? 16'h8000 : neg_q[15:0];
        end else begin
            sat_val = (r_q > 17'd32767) ? 16'h7FFF : r_q[15:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_step      = r_step;
        n_gain      = r_gain;
        n_active    = r_active;
        n_oct       = r_oct;
        n_semi      = r_semi;
        n_st        = r_st;
        n_psum      = r_psum;
        n_t0        = r_t0;
        n_v         = r_v;
        n_x         = r_x;
        n_neg       = r_neg;
        n_q         = r_q;
        n_sound     = r_sound;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_data.operation)
                        OP_NOTE: begin
                            n_oct   = nsplit.oct;
                            n_semi  = nsplit.semi;
                            n_gain  = i_data.velocity;
                            n_state = S_NMUL;
                        end
                        OP_STOP: n_active = 1'b0;
                        OP_TICK: begin
                            if (r_active) begin
                                n_phase = phase_eff;
                                n_st    = st_clamp;
                                n_sound = 1'b1;
                                n_state = S_RD0;
                            end else begin
                                n_q     = '0;
                                n_neg   = 1'b0;
                                n_sound = 1'b0;
                                n_state = S_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_NMUL: n_state = S_NFIN;
            S_NFIN: begin
                if (rshift[31:0] > {5'd0, lim_m1}) begin
                    n_step = lim_m1[PHASE_W-1:0];
                end else begin
                    n_step = rshift[PHASE_W-1:0];
                end
                n_phase  = '0;
                n_active = 1'b1;
                n_state  = S_IDLE;
            end
            S_RD0: n_state = S_RD1;
            S_RD1: begin
                n_t0    = t_rd;
                n_psum  = {1'b0, r_phase} + {1'b0, r_st};
                n_state = S_MUL1;
            end
            S_MUL1: n_state = S_SUM;
            S_SUM: begin
                n_v = {r_t0[15], r_t0, {FRAC_BITS{1'b0}}} + m_p[32:0];
                if (r_psum >= lim) begin
                    n_psum = r_psum - lim;
                end
                n_phase = (r_psum >= lim) ? n_psum[PHASE_W-1:0] : r_psum[PHASE_W-1:0];
                n_state = S_GAIN;
            end
            S_GAIN: n_state = S_RND;
            S_RND: begin
                n_neg   = p_raw[39];
                n_x     = p_rnd[38:16];
                n_state = S_DIV;
            end
            S_DIV: n_state = S_FIX;
            S_FIX: begin
                n_q     = (rem >= 24'd127) ? q0 + 17'd1 : q0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    n_out.sample   = sat_val;
                    n_out.sounding = r_sound;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_step      <= '0;
            r_gain      <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_gain      <= n_gain;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oct   <= n_oct;
        r_semi  <= n_semi;
        r_st    <= n_st;
        r_psum  <= n_psum;
        r_t0    <= n_t0;
        r_v     <= n_v;
        r_x     <= n_x;
        r_neg   <= n_neg;
        r_q     <= n_q;
        r_sound <= n_sound;
        r_out   <= n_out;
    end

endmodule

### rtl/core/wtosc_chk.sv
// Port-level checker for the wavetable oscillator, bound to the top level.
// Depends on wtosc_pkg and the assertion macros header.
`include "wavetable_oscillator_interp_top_defines.svh"

module wtosc_chk
    import wtosc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_word  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_data
);

    // a stalled result word holds
    `WTOSC_AST_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))

    // a silent word carries a zero sample
    `WTOSC_AST_NOW(a_silent_zero, i_clk, i_rst_n, o_valid && !o_data.sounding, o_data.sample == 16'sd0)

    // note on and tick occupy the sequencer
    `WTOSC_AST_NEXT(a_busy_after_work, i_clk, i_rst_n, i_valid && o_ready && (i_data.operation == OP_NOTE || i_data.operation == OP_TICK), !o_ready)

    // load and stop leave the sequencer idle
    `WTOSC_AST_NEXT(a_ready_after_short, i_clk, i_rst_n, i_valid && o_ready && (i_data.operation == OP_LOAD || i_data.operation == OP_STOP), o_ready)

endmodule

bind wavetable_oscillator_interp_top wtosc_chk u_wtosc_chk (.*);

### tb/tb.sv
// Self-checking bench for the wavetable oscillator with linear interpolation.
// Depends on wtosc_pkg and wavetable_oscillator_interp_top; a behavioral
// predictor in this file supplies the expected tick samples.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wtosc_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;
    // entries loaded before any long table is played; later lengths stay within it
    localparam int FILL_COUNT   = 512;

    // 2^(k/12), unsigned Q1.16
    localparam longint unsigned SEMI_RATIO [12] = '{
        65536, 69433, 73562, 77936, 82570, 87480,
        92682, 98193, 104032, 110218, 116772, 123715
    };

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_word    i_data  = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_word   o_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    wavetable_oscillator_interp_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // predictor state
    logic signed [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];
    longint unsigned osc_phase = 0;
    longint unsigned osc_step  = 0;
    longint unsigned osc_gain  = 0;
    bit              osc_on    = 1'b0;
    longint unsigned cfg_a440  = A440_RESET;
    longint unsigned cfg_len   = LEN_RESET;

    t_out_word pending_samples [$];
    int  errors        = 0;
    int  words_in      = 0;
    int  words_out     = 0;
    int  reg_writes    = 0;
    int  idle_count    = 0;
    bit  idle_on       = 1'b1;
    int  rx_stall_left = 0;
    int  hold_request  = 0;

    function automatic longint unsigned eff_len();
        longint unsigned l;
        l = cfg_len;
        if (l < LEN_MIN) l = LEN_MIN;
        if (l > LEN_MAX) l = LEN_MAX;
        return l;
    endfunction

    function automatic t_out_word next_sample();
        longint unsigned len, lim, st, i0, i1, frac;
        longint t0, t1, v, p, q, den;
        t_out_word r;
        len = eff_len();
        lim = len << FRAC_BITS;
        if (osc_phase >= lim) osc_phase = 0;
        st = osc_step;
        if (st > lim - 1) st = lim - 1;
        i0 = osc_phase >> FRAC_BITS;
        i1 = i0 + 1;
        if (i1 >= len) i1 = 0;
        frac = osc_phase & ((64'd1 << FRAC_BITS) - 1);
        t0 = wave_mem[i0];
        t1 = wave_mem[i1];
        v = t0 * (longint'(1) << FRAC_BITS) + (t1 - t0) * longint'(frac);
        p = v * longint'(osc_gain);
        den = longint'(127) << FRAC_BITS;
        // round half away from zero
        if (p >= 0) q = (p + den / 2) / den;
        else q = -((-p + den / 2) / den);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        osc_phase = osc_phase + st;
        if (osc_phase >= lim) osc_phase = osc_phase - lim;
        r.sample   = q[SAMPLE_W-1:0];
        r.sounding = 1'b1;
        return r;
    endfunction

    function automatic void osc_apply(input t_in_word w, output bit has_r,
                                      output t_out_word r);
        int unsigned n, oct, semi, sh;
        longint unsigned prod, st, lim;
        has_r = 1'b0;
        r = '0;
        case (w.operation)
            OP_LOAD: wave_mem[w.table_index] = w.table_value;
            OP_NOTE: begin
                n    = w.note + 3;
                oct  = n / 12;
                semi = n % 12;
                sh   = 22 - oct;
                prod = cfg_a440 * SEMI_RATIO[semi];
                st   = (prod + (64'd1 << (sh - 1))) >> sh;
                lim  = (eff_len() << FRAC_BITS) - 1;
                if (st > lim) st = lim;
                osc_step  = st;
                osc_phase = 0;
                osc_gain  = w.velocity;
                osc_on    = 1'b1;
            end
            OP_STOP: osc_on = 1'b0;
            OP_TICK: begin
                has_r = 1'b1;
                if (osc_on) r = next_sample();
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65) return 0;
        if (sel < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_word random_word(input t_op op);
        logic [63:0] bits;
        t_in_word w;
        bits = {$urandom, $urandom};
        w = bits[$bits(t_in_word)-1:0];
        w.operation = op;
        return w;
    endfunction

    function automatic t_in_word note_word(input int note, input int vel);
        t_in_word w;
        w = random_word(OP_NOTE);
        w.note     = note[NOTE_W-1:0];
        w.velocity = vel[GAIN_W-1:0];
        return w;
    endfunction

    function automatic t_in_word load_word(input int idx, input int value);
        t_in_word w;
        w = random_word(OP_LOAD);
        w.table_index = idx[IDX_W-1:0];
        w.table_value = value[SAMPLE_W-1:0];
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        errors++;
        if (errors <= 40)
            $display("mismatch at output word %0d: %s expected %0d got %0d",
                     words_out, what, want_v, got_v);
    endtask

    // send one word; valid stays up into the next word when no gap is drawn
    task automatic send_word(input t_in_word w);
        int gap;
        bit has_r;
        t_out_word r;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
        osc_apply(w, has_r, r);
        if (has_r) pending_samples.push_back(r);
        words_in++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_word(random_word(OP_TICK));
    endtask

    // all results in, then let any load/note/stop word still in flight finish
    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_A440: cfg_a440 = value[A440_W-1:0];
            REG_LEN:  cfg_len  = value[LEN_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_config(input logic [31:0] a440, input logic [31:0] len);
        wait_drain();
        write_reg(REG_A440, a440);
        write_reg(REG_LEN, len);
    endtask

    // ticks, stops before any note: silent
    task automatic test_idle_ticks();
        send_word(random_word(OP_TICK));
        send_word(random_word(OP_STOP));
        send_word(random_word(OP_TICK));
    endtask

    // two-entry table with the sample extremes, clamped steps, gain extremes
    task automatic test_directed();
        set_config(A440_RESET, 0);
        send_word(load_word(0, 32767));
        send_word(load_word(1, -32768));
        send_word(load_word(TABLE_DEPTH - 1, -1));
        send_word(note_word(127, 127));
        send_ticks(3);
        send_word(note_word(0, 0));
        send_ticks(2);
        send_word(note_word(69, 127));
        send_ticks(3);
        send_word(note_word(69, 1));
        send_ticks(2);
        send_word(random_word(OP_STOP));
        send_word(random_word(OP_TICK));
    endtask

    // lower part of the table written, length above the table depth
    task automatic test_table_fill();
        int value;
        set_config(A440_RESET, 2047);
        for (int i = 0; i < FILL_COUNT; i++) begin
            case (i % 97)
                0:       value = 32767;
                1:       value = -32768;
                2:       value = 0;
                default: value = $urandom;
            endcase
            send_word(load_word(i, value));
        end
        send_word(note_word(81, 127));
        send_ticks(8);
    endtask

    // shrink the table under a running note: phase resets, step re-clamped
    task automatic test_length_change();
        set_config(A440_RESET, FILL_COUNT);
        send_word(note_word(100, 127));
        send_ticks(20);
        wait_drain();
        write_reg(REG_LEN, 4);
        send_ticks(10);
    endtask

    // receiver holds off while ticks keep coming, so the input backs up
    task automatic test_output_stall();
        set_config(A440_RESET, FILL_COUNT);
        idle_on = 1'b0;
        send_word(note_word(60, 100));
        hold_request = HOLD_CYCLES;
        send_ticks(60);
        idle_on = 1'b1;
    endtask

    task automatic test_random_mix(input int rounds, input int words_per_round);
        logic [31:0] a440, len;
        int count, sel, n, vel;
        for (int rnd = 0; rnd < rounds; rnd++) begin
            case ($urandom_range(0, 4))
                0:       a440 = 0;
                1:       a440 = 32'h3FF_FFFF;
                2:       a440 = A440_RESET;
                3:       a440 = $urandom_range(0, 32'h3FF_FFFF);
                default: a440 = $urandom_range(20000, 2000000);
            endcase
            case ($urandom_range(0, 6))
                0:       len = $urandom_range(0, 1);
                1:       len = 2;
                2:       len = 3;
                3:       len = FILL_COUNT;
                4:       len = $urandom_range(FILL_COUNT / 2, FILL_COUNT);
                default: len = $urandom_range(2, FILL_COUNT);
            endcase
            if (rnd == 0) begin
                a440 = 0;
                len  = 2;
            end else if (rnd == 1) begin
                a440 = 32'h3FF_FFFF;
                len  = FILL_COUNT;
            end
            set_config(a440, len);
            idle_on = (rnd % 3 != 2);
            count = 0;
            while (count < words_per_round) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    case ($urandom_range(0, 9))
                        0:       vel = 0;
                        1:       vel = 127;
                        default: vel = $urandom_range(0, 127);
                    endcase
                    send_word(note_word($urandom_range(0, 127), vel));
                    n = $urandom_range(1, 10);
                    send_ticks(n);
                    count += n + 1;
                end else begin
                    if (sel < 80)
                        send_word(load_word($urandom_range(0, FILL_COUNT - 1), $urandom));
                    else if (sel < 88)
                        send_word(random_word(OP_STOP));
                    else
                        send_word(random_word(OP_TICK));
                    count++;
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // receiver: random stalls plus the requested long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                i_ready <= 1'b0;
            end else if (hold_request > 0) begin
                rx_stall_left = hold_request - 1;
                hold_request  = 0;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 15) begin
                rx_stall_left = pick_gap();
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_output
        t_out_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("word with no prediction, sample", 0, int'(o_data.sample));
            end else begin
                want = pending_samples.pop_front();
                if (o_data.sample !== want.sample)
                    report_mismatch("sample", int'(want.sample), int'(o_data.sample));
                if (o_data.sounding !== want.sounding)
                    report_mismatch("sounding", int'(want.sounding), int'(o_data.sounding));
            end
            words_out++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     idle_count, pending_samples.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) wave_mem[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_ticks();
        test_directed();
        test_table_fill();
        test_length_change();
        test_output_stall();
        test_random_mix(5, 50);
        wait_drain();
        $display("Covered %0d input words and %0d output words across %0d register writes:",
                 words_in, words_out, reg_writes);
        $display("table loads, note on at all octaves, stops, clamps and length changes.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
